>>> src/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check with reset gating; clk and rst_n must be visible at the use site.
`define CTA_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Implication form of the above.
`define CTA_ASSERT_IMP(label, pre, post, msg) \
    `CTA_ASSERT(label, (pre) |-> (post), msg)

`endif

>>> src/cta_pkg.sv
package cta_pkg;

    localparam int WORD_BITS_DEF = 64;
    localparam int VAL_BITS      = 64;

    localparam logic [4:0] ACT_ADD      = 5'd0;
    localparam logic [4:0] ACT_SUB      = 5'd1;
    localparam logic [4:0] ACT_MUL      = 5'd2;
    localparam logic [4:0] ACT_DIV      = 5'd3;
    localparam logic [4:0] ACT_MOD      = 5'd4;
    localparam logic [4:0] ACT_NEG      = 5'd5;
    localparam logic [4:0] ACT_INC      = 5'd6;
    localparam logic [4:0] ACT_DEC      = 5'd7;
    localparam logic [4:0] ACT_NOT      = 5'd8;
    localparam logic [4:0] ACT_AND      = 5'd9;
    localparam logic [4:0] ACT_OR       = 5'd10;
    localparam logic [4:0] ACT_IDENT    = 5'd11;
    localparam logic [4:0] ACT_LT       = 5'd12;
    localparam logic [4:0] ACT_GT       = 5'd13;
    localparam logic [4:0] ACT_LE       = 5'd14;
    localparam logic [4:0] ACT_GE       = 5'd15;
    localparam logic [4:0] ACT_BOOLTEST = 5'd16;

    localparam logic [2:0] TAG_INT  = 3'd0;
    localparam logic [2:0] TAG_BOOL = 3'd3;

    localparam logic [1:0] ERR_NONE = 2'd0;
    localparam logic [1:0] ERR_TYPE = 2'd1;
    localparam logic [1:0] ERR_OVF  = 2'd2;
    localparam logic [1:0] ERR_DIV0 = 2'd3;

    // Per-transaction control that rides alongside the datapath cells.
    typedef struct packed {
        logic                is_mul;
        logic                is_div;
        logic                is_mod;
        logic                neg_q;
        logic                neg_r;
        logic [1:0]          err;
        logic [2:0]          rtype;
        logic [VAL_BITS-1:0] value;
    } cta_ctl_t;

endpackage

>>> src/cta_req_if.sv
interface cta_req_if;
    logic        valid;
    logic        ready;
    logic [4:0]  action;
    logic [2:0]  a_type;
    logic [63:0] a_value;
    logic [2:0]  b_type;
    logic [63:0] b_value;

    modport source (output valid, action, a_type, a_value, b_type, b_value, input ready);
    modport sink   (input valid, action, a_type, a_value, b_type, b_value, output ready);
endinterface

>>> src/cta_rsp_if.sv
interface cta_rsp_if;
    logic        valid;
    logic        ready;
    logic [2:0]  result_type;
    logic [63:0] result_value;
    logic [1:0]  error_code;

    modport source (output valid, result_type, result_value, error_code, input ready);
    modport sink   (input valid, result_type, result_value, error_code, output ready);
endinterface

>>> src/cta_cell.sv
module cta_cell #(
    parameter int W   = 64,
    parameter int IDX = 0
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  cta_pkg::cta_ctl_t  ctl_in,
    input  logic [W-1:0]       mcand_in,
    input  logic [W-1:0]       mplier_in,
    input  logic [W-1:0]       divisor_in,
    input  logic [W-1:0]       dq_in,
    input  logic [W-1:0]       rem_in,
    input  logic [2*W-1:0]     prod_in,
    output logic               out_valid,
    input  logic               out_ready,
    output cta_pkg::cta_ctl_t  ctl_out,
    output logic [W-1:0]       mcand_out,
    output logic [W-1:0]       mplier_out,
    output logic [W-1:0]       divisor_out,
    output logic [W-1:0]       dq_out,
    output logic [W-1:0]       rem_out,
    output logic [2*W-1:0]     prod_out
);
    import cta_pkg::*;

    logic             valid_reg;
    cta_ctl_t         ctl_reg;
    logic [W-1:0]     mcand_reg, mplier_reg, divisor_reg, dq_reg, rem_reg;
    logic [2*W-1:0]   prod_reg;

    logic [W:0]       rem_sh, diff;
    logic             ge;
    logic [W-1:0]     rem_next, dq_next, mplier_next;
    logic [2*W-1:0]   prod_next, addend;

    // one restoring divide step and one shift-add multiply step
    always_comb
    begin
        rem_sh      = {rem_in, dq_in[W-1]};
        diff        = rem_sh - {1'b0, divisor_in};
        ge          = !diff[W];
        rem_next    = ge ? diff[W-1:0] : rem_sh[W-1:0];
        dq_next     = {dq_in[W-2:0], ge};
        addend      = mplier_in[0] ? ({{W{1'b0}}, mcand_in} << IDX) : '0;
        prod_next   = prod_in + addend;
        mplier_next = mplier_in >> 1;
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            ctl_reg     <= ctl_in;
            mcand_reg   <= mcand_in;
            mplier_reg  <= mplier_next;
            divisor_reg <= divisor_in;
            dq_reg      <= dq_next;
            rem_reg     <= rem_next;
            prod_reg    <= prod_next;
        end
    end

    assign out_valid   = valid_reg;
    assign ctl_out     = ctl_reg;
    assign mcand_out   = mcand_reg;
    assign mplier_out  = mplier_reg;
    assign divisor_out = divisor_reg;
    assign dq_out      = dq_reg;
    assign rem_out     = rem_reg;
    assign prod_out    = prod_reg;
endmodule

>>> src/checked_typed_alu.sv
// Type-checked signed integer / boolean ALU. One transaction per clock is
// accepted while rsp.ready does not stall the pipeline, and one result is
// delivered per transaction, in order. Each request, once taken, passes
// a row of WORD_BITS cells, each doing one quotient bit and one multiplier bit,
// then an output register. Integer math uses the low WORD_BITS bits of each
// value, sign-extended to 64 on output. Errors (wrong type, overflow, divide by
// zero) give int 0 with the error code; actions above 16 give int 0, no error.
module checked_typed_alu #(
    parameter int WORD_BITS = cta_pkg::WORD_BITS_DEF
) (
    input  logic  clk,
    input  logic  rst_n,
    cta_req_if.sink   req,
    cta_rsp_if.source rsp
);
    import cta_pkg::*;
`include "assert_macros.svh"

    localparam int W = WORD_BITS;
    localparam logic [W-1:0] MINV = {1'b1, {(W-1){1'b0}}};
    localparam logic [W-1:0] MAXV = ~MINV;

    // ---------------- front end ----------------
    logic [W-1:0] a_w, b_w, a_mag, b_mag;
    logic [W:0]   sum, dif;
    logic         unary, want_bool, type_bad;
    logic [2:0]   need;
    cta_ctl_t     ctl0;

    always_comb
    begin
        a_w   = req.a_value[W-1:0];
        b_w   = req.b_value[W-1:0];
        a_mag = a_w[W-1] ? (~a_w + 1'b1) : a_w;
        b_mag = b_w[W-1] ? (~b_w + 1'b1) : b_w;
        sum   = {a_w[W-1], a_w} + {b_w[W-1], b_w};
        dif   = {a_w[W-1], a_w} - {b_w[W-1], b_w};
        unary     = req.action inside {ACT_NEG, ACT_INC, ACT_DEC, ACT_NOT, ACT_BOOLTEST};
        want_bool = req.action inside {ACT_NOT, ACT_AND, ACT_OR, ACT_BOOLTEST};
        need      = want_bool ? TAG_BOOL : TAG_INT;
        type_bad  = (req.a_type != need) || (!unary && req.b_type != need);

        ctl0       = '0;
        ctl0.rtype = TAG_INT;
        ctl0.err   = ERR_NONE;
        ctl0.neg_q = a_w[W-1] ^ b_w[W-1];
        ctl0.neg_r = a_w[W-1];

        if (req.action > ACT_BOOLTEST)
        begin
            ctl0.rtype = TAG_INT;
        end
        else if (req.action == ACT_IDENT)
        begin
            ctl0.rtype = TAG_BOOL;
            ctl0.value = VAL_BITS'(req.a_type == req.b_type && req.a_value == req.b_value);
        end
        else
        begin
            ctl0.rtype = (want_bool || req.action >= ACT_LT) ? TAG_BOOL : TAG_INT;
            if (type_bad)
            begin
                ctl0.err = ERR_TYPE;
            end
            else
            begin
                case (req.action)
                    ACT_ADD:
                    begin
                        if (sum[W] != sum[W-1]) ctl0.err = ERR_OVF;
                        else ctl0.value = VAL_BITS'($signed(sum[W-1:0]));
                    end
                    ACT_SUB:
                    begin
                        if (dif[W] != dif[W-1]) ctl0.err = ERR_OVF;
                        else ctl0.value = VAL_BITS'($signed(dif[W-1:0]));
                    end
                    ACT_MUL: ctl0.is_mul = 1'b1;
                    ACT_DIV, ACT_MOD:
                    begin
                        if (b_w == '0) ctl0.err = ERR_DIV0;
                        else if (a_w == MINV && b_w == '1) ctl0.err = ERR_OVF;
                        else if (req.action == ACT_DIV) ctl0.is_div = 1'b1;
                        else ctl0.is_mod = 1'b1;
                    end
                    ACT_NEG:
                    begin
                        if (a_w == MINV) ctl0.err = ERR_OVF;
                        else ctl0.value = VAL_BITS'($signed(W'(~a_w + 1'b1)));
                    end
                    ACT_INC:
                    begin
                        if (a_w == MAXV) ctl0.err = ERR_OVF;
                        else ctl0.value = VAL_BITS'($signed(W'(a_w + 1'b1)));
                    end
                    ACT_DEC:
                    begin
                        if (a_w == MINV) ctl0.err = ERR_OVF;
                        else ctl0.value = VAL_BITS'($signed(W'(a_w - 1'b1)));
                    end
                    ACT_NOT: ctl0.value = VAL_BITS'(req.a_value == '0);
                    ACT_AND: ctl0.value = VAL_BITS'(req.a_value != '0 && req.b_value != '0);
                    ACT_OR:  ctl0.value = VAL_BITS'(req.a_value != '0 || req.b_value != '0);
                    ACT_LT:  ctl0.value = VAL_BITS'($signed(a_w) <  $signed(b_w));
                    ACT_GT:  ctl0.value = VAL_BITS'($signed(a_w) >  $signed(b_w));
                    ACT_LE:  ctl0.value = VAL_BITS'($signed(a_w) <= $signed(b_w));
                    ACT_GE:  ctl0.value = VAL_BITS'($signed(a_w) >= $signed(b_w));
                    default: ctl0.value = VAL_BITS'(req.a_value != '0);
                endcase
            end
        end

        if (ctl0.err != ERR_NONE)
        begin
            ctl0.rtype  = TAG_INT;
            ctl0.value  = '0;
            ctl0.is_mul = 1'b0;
            ctl0.is_div = 1'b0;
            ctl0.is_mod = 1'b0;
        end
    end

    // ---------------- cell row ----------------
    logic           c_valid [0:W];
    logic           c_ready [0:W];
    cta_ctl_t       c_ctl   [0:W];
    logic [W-1:0]   c_mcand [0:W];
    logic [W-1:0]   c_mplier[0:W];
    logic [W-1:0]   c_div   [0:W];
    logic [W-1:0]   c_dq    [0:W];
    logic [W-1:0]   c_rem   [0:W];
    logic [2*W-1:0] c_prod  [0:W];

    assign c_valid[0]  = req.valid;
    assign req.ready   = c_ready[0];
    assign c_ctl[0]    = ctl0;
    assign c_mcand[0]  = a_mag;
    assign c_mplier[0] = b_mag;
    assign c_div[0]    = b_mag;
    assign c_dq[0]     = a_mag;
    assign c_rem[0]    = '0;
    assign c_prod[0]   = '0;

    genvar i;
    generate
        for (i = 0; i < W; i++)
        begin : g_cell
            cta_cell #(.W(W), .IDX(i)) u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .in_valid   (c_valid[i]),
                .in_ready   (c_ready[i]),
                .ctl_in     (c_ctl[i]),
                .mcand_in   (c_mcand[i]),
                .mplier_in  (c_mplier[i]),
                .divisor_in (c_div[i]),
                .dq_in      (c_dq[i]),
                .rem_in     (c_rem[i]),
                .prod_in    (c_prod[i]),
                .out_valid  (c_valid[i+1]),
                .out_ready  (c_ready[i+1]),
                .ctl_out    (c_ctl[i+1]),
                .mcand_out  (c_mcand[i+1]),
                .mplier_out (c_mplier[i+1]),
                .divisor_out(c_div[i+1]),
                .dq_out     (c_dq[i+1]),
                .rem_out    (c_rem[i+1]),
                .prod_out   (c_prod[i+1])
            );
        end
    endgenerate

    // ---------------- back end ----------------
    cta_ctl_t     tail;
    logic [W-1:0] q_s, r_s, lo, m_s, lim;
    logic         mul_ovf;
    logic [2:0]   type_next;
    logic [63:0]  value_next;
    logic [1:0]   err_next;

    always_comb
    begin
        tail    = c_ctl[W];
        q_s     = tail.neg_q ? (~c_dq[W] + 1'b1) : c_dq[W];
        r_s     = tail.neg_r ? (~c_rem[W] + 1'b1) : c_rem[W];
        lo      = c_prod[W][W-1:0];
        lim     = tail.neg_q ? MINV : MAXV;
        mul_ovf = (c_prod[W][2*W-1:W] != '0) || (lo > lim);
        m_s     = tail.neg_q ? (~lo + 1'b1) : lo;

        type_next  = tail.rtype;
        value_next = tail.value;
        err_next   = tail.err;
        if (tail.is_mul)
        begin
            if (mul_ovf)
            begin
                err_next   = ERR_OVF;
                type_next  = TAG_INT;
                value_next = '0;
            end
            else
            begin
                value_next = VAL_BITS'($signed(m_s));
            end
        end
        else if (tail.is_div)
        begin
            value_next = VAL_BITS'($signed(q_s));
        end
        else if (tail.is_mod)
        begin
            value_next = VAL_BITS'($signed(r_s));
        end
    end

    logic        out_valid_reg;
    logic [2:0]  type_reg;
    logic [63:0] value_reg;
    logic [1:0]  err_reg;

    assign c_ready[W] = !out_valid_reg || rsp.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (c_ready[W])
        begin
            out_valid_reg <= c_valid[W];
        end
    end

    always_ff @(posedge clk)
    begin
        if (c_ready[W] && c_valid[W])
        begin
            type_reg  <= type_next;
            value_reg <= value_next;
            err_reg   <= err_next;
        end
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.result_type  = type_reg;
    assign rsp.result_value = value_reg;
    assign rsp.error_code   = err_reg;

    // ---------------- checks ----------------
    `CTA_ASSERT_IMP(a_err_zero, rsp.valid && rsp.error_code != ERR_NONE,
        rsp.result_type == TAG_INT && rsp.result_value == '0, "error result not int zero")
    `CTA_ASSERT_IMP(a_bool_range, rsp.valid && rsp.result_type == TAG_BOOL,
        rsp.result_value[63:1] == '0, "bool result not 0 or 1")
    `CTA_ASSERT_IMP(a_tag_set, rsp.valid,
        rsp.result_type == TAG_INT || rsp.result_type == TAG_BOOL, "bad result tag")
    `CTA_ASSERT_IMP(a_tail_advance, c_valid[W] && !out_valid_reg,
        ##1 out_valid_reg, "tail result not captured")
endmodule
